// ===== sv/html_text_cleaner_assert.svh =====
// Assertion macros for the HTML text cleaner.
`ifndef HTML_TEXT_CLEANER_ASSERT_SVH
`define HTML_TEXT_CLEANER_ASSERT_SVH
`ifndef SYNTH
`define HTC_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);
`define HTC_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define HTC_ALWAYS(name, expr, msg)
`define HTC_NEXT(name, cond, expr, msg)
`endif
`endif

// ===== sv/htc_pkg.sv =====
// Types, character codes and entity table shared by the HTML text cleaner.
`timescale 1ns / 1ps
`default_nettype none
package htc_pkg;

    localparam int CAP_W = 13;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd256;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5a;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CASE_OFS = 8'h20;
    localparam logic [7:0] HEX_OFS  = 8'h57;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7f;

    localparam int ENT_NUM = 6;
    localparam logic [7:0] ENT_TEXT [ENT_NUM][6] = '{
        '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
        '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00},
        '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
        '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
        '{8'h26, 8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b}
    };
    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6, 3'd6};
    localparam logic [7:0] ENT_CHAR [ENT_NUM] = '{8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h20};

    typedef enum logic [3:0] {
        ST_IDLE, ST_POST, ST_DEC, ST_NUM, ST_EMIT, ST_REPLAY, ST_TAKE, ST_TAKE2, ST_FINAL
    } state_t;

    typedef struct packed {
        logic       put;
        logic       fin;
        logic       bare;
        logic [7:0] data;
    } out_req_t;

    typedef struct packed {
        logic put_ok;
        logic fin_ok;
        logic fin_done;
    } out_st_t;

    typedef struct packed {
        logic       full;
        logic       partial;
        logic [2:0] len;
        logic [7:0] ch;
    } ent_res_t;

    function automatic ent_res_t ent_match(input logic [5:0][7:0] taps, input logic [3:0] k);
        ent_res_t r;
        logic     m;
        int       e;
        int       i;
        r = '0;
        for (e = 0; e < ENT_NUM; e++) begin
            m = 1'b1;
            for (i = 0; i < 6; i++) begin
                if (i < int'(ENT_LEN[e]) && i < int'(k) && taps[i] != ENT_TEXT[e][i]) begin
                    m = 1'b0;
                end
            end
            if (m) begin
                if (k >= {1'b0, ENT_LEN[e]}) begin
                    r.full = 1'b1;
                    r.len  = ENT_LEN[e];
                    r.ch   = ENT_CHAR[e];
                end else begin
                    r.partial = 1'b1;
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== sv/htc_digit_unit.sv =====
// Digit classifier and accumulate step for numeric character references.
`timescale 1ns / 1ps
`default_nettype none
module htc_digit_unit
    import htc_pkg::*;
#(
    parameter int V_W = 24
) (
    input  wire logic [7:0]     ch,
    input  wire logic           hex,
    input  wire logic [V_W-1:0] acc,
    output logic                is_digit,
    output logic [V_W-1:0]      acc_next
);

    logic [7:0] lc;
    logic [3:0] dv;

    always_comb begin
        lc       = (ch >= CH_UA && ch <= CH_UZ) ? ch + CASE_OFS : ch;
        is_digit = 1'b0;
        dv       = 4'd0;
        if (lc >= CH_0 && lc <= CH_9) begin
            is_digit = 1'b1;
            dv       = lc[3:0];
        end else if (hex && lc >= CH_LA && lc <= CH_LF_HEX) begin
            is_digit = 1'b1;
            dv       = 4'(lc - HEX_OFS);
        end
        acc_next = hex ? ((acc << 4) | V_W'(dv)) : ((acc << 3) + (acc << 1) + V_W'(dv));
    end

endmodule
`default_nettype wire

// ===== sv/htc_out_stage.sv =====
// Result staging: holds the newest byte back until the span end, which marks it last unless the final step put nothing.
`timescale 1ns / 1ps
`default_nettype none
module htc_out_stage
    import htc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire out_req_t req,
    output out_st_t       st,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic          m_tuser,   // out_valid
    output logic          m_tlast
);

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_byte_reg, m_byte_next;
    logic       m_user_reg, m_user_next;
    logic       m_last_reg, m_last_next;
    logic       pend_v_reg, pend_v_next;
    logic [7:0] pend_reg, pend_next;
    logic       m_free;

    assign m_free      = !m_valid_reg || m_tready;
    assign st.put_ok   = !pend_v_reg || m_free;
    assign st.fin_ok   = m_free;
    // a held byte from an earlier step goes out unmarked, then the bare end marker
    assign st.fin_done = m_free && !(pend_v_reg && req.bare);

    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        m_byte_next  = m_byte_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        pend_v_next  = pend_v_reg;
        pend_next    = pend_reg;
        if (req.put && st.put_ok) begin
            if (pend_v_reg) begin
                m_valid_next = 1'b1;
                m_byte_next  = pend_reg;
                m_user_next  = 1'b1;
                m_last_next  = 1'b0;
            end
            pend_v_next = 1'b1;
            pend_next   = req.data;
        end else if (req.fin && st.fin_ok) begin
            m_valid_next = 1'b1;
            m_byte_next  = pend_v_reg ? pend_reg : 8'd0;
            m_user_next  = pend_v_reg;
            m_last_next  = !(pend_v_reg && req.bare);
            pend_v_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_v_reg  <= pend_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
        pend_reg   <= pend_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule
`default_nettype wire

// ===== sv/html_text_cleaner.sv =====
// HTML text cleaner: one small sequencer takes one byte at a time through whitespace
// collapsing, entity and numeric reference decoding, UTF-8 tail holding and the output
// limit. A plain byte passes through the take, emit and post steps; a byte that completes
// or fails a reference adds the entity check, the digit scan and a replay of the bytes
// still buffered behind it, each going through the same take and emit steps again. The
// byte with tlast set adds the final settle and the end-marked result, sent after the held
// byte as a bare marker when that byte produced nothing while an earlier byte of the span
// is still held back. All of it runs in the one sequencer and its digit unit, and
// s_tready is high only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "html_text_cleaner_assert.svh"
module html_text_cleaner
    import htc_pkg::*;
#(
    parameter int MAX_DIGITS      = 6,
    parameter int LOOKAHEAD_DEPTH = 10
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,   // in_byte
    input  wire logic             s_tlast,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [7:0]            m_tdata,   // out_byte
    output logic                  m_tuser,   // out_valid
    output logic                  m_tlast,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CAP_W-1:0] cfg_data
);

    localparam int IW  = $clog2(LOOKAHEAD_DEPTH);
    localparam int CW  = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int V_W = 4 * MAX_DIGITS;

    state_t           state_reg, state_next;
    logic [CAP_W-1:0] cap_reg;
    logic [7:0]       lb_reg [LOOKAHEAD_DEPTH];
    logic [CW-1:0]    la_cnt_reg, la_cnt_next;
    logic [CAP_W-1:0] cnt_reg, cnt_next;
    logic             sp_reg, sp_next;
    logic [7:0]       held_reg [3];
    logic [1:0]       held_cnt_reg, held_cnt_next;
    logic [2:0]       want_reg, want_next;
    logic             reached_reg, reached_next;
    logic             last_reg, last_next;
    logic             ended_reg, ended_next;
    logic             step_put_reg, step_put_next;
    logic [7:0]       take_c_reg, take_c_next;
    state_t           take_ret_reg, take_ret_next;
    logic [7:0]       emit_c_reg, emit_c_next;
    state_t           emit_ret_reg, emit_ret_next;
    logic [1:0]       fi_reg, fi_next;
    logic [CW-1:0]    j_reg, j_next;
    logic [CW-1:0]    d0_reg, d0_next;
    logic             hex_reg, hex_next;
    logic [V_W-1:0]   v_reg, v_next;
    logic [CW-1:0]    rp_src_reg, rp_src_next;
    logic [CW-1:0]    rp_end_reg, rp_end_next;

    logic             lb_we;
    logic [IW-1:0]    lb_wa;
    logic [7:0]       lb_wd;
    logic             held_we;
    logic [1:0]       held_wa;
    logic [7:0]       held_wd;

    logic             s_acc;
    logic [IW-1:0]    rd_idx;
    logic [7:0]       rd_byte;
    logic [5:0][7:0]  taps;
    ent_res_t         em;
    logic             du_digit;
    logic [V_W-1:0]   du_acc;

    logic             dec_go, dec_wait, num_start, num_step;
    logic [CW-1:0]    dec_len;
    logic [7:0]       dec_ch;

    logic             e_cont, held_nz, e_flush, e_flushing, e_final_put, e_put, e_adv;
    logic [2:0]       e_want;

    logic             t_ws, cap_hit1, cap_hit2;

    out_req_t         oreq;
    out_st_t          ost;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign rd_idx  = (state_reg == ST_NUM) ? j_reg[IW-1:0] : rp_src_reg[IW-1:0];
    assign rd_byte = lb_reg[rd_idx];

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            taps[i] = lb_reg[i];
        end
    end

    assign em = ent_match(taps, 4'(la_cnt_reg));

    htc_digit_unit #(.V_W(V_W)) u_digit (
        .ch       (rd_byte),
        .hex      (hex_reg),
        .acc      (v_reg),
        .is_digit (du_digit),
        .acc_next (du_acc)
    );

    htc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (oreq),
        .st       (ost),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // reference decision
    always_comb begin
        logic und;
        logic fail;
        und       = 1'b0;
        fail      = 1'b0;
        dec_go    = 1'b0;
        dec_wait  = 1'b0;
        num_start = 1'b0;
        num_step  = 1'b0;
        dec_len   = CW'(1);
        dec_ch    = CH_AMP;
        if (state_reg == ST_DEC) begin
            if (em.full) begin
                dec_go  = 1'b1;
                dec_len = CW'(em.len);
                dec_ch  = em.ch;
            end else if (em.partial && !ended_reg) begin
                und = 1'b1;
            end else if (la_cnt_reg < CW'(2)) begin
                und  = !ended_reg;
                fail = ended_reg;
            end else if (lb_reg[1] != CH_HASH) begin
                fail = 1'b1;
            end else if (la_cnt_reg < CW'(3)) begin
                und  = !ended_reg;
                fail = ended_reg;
            end else begin
                num_start = 1'b1;
            end
        end else if (state_reg == ST_NUM) begin
            if (j_reg >= la_cnt_reg) begin
                und  = !ended_reg;
                fail = ended_reg;
            end else if (rd_byte == CH_SEMI || 32'(j_reg - d0_reg) >= MAX_DIGITS
                         || !du_digit) begin
                if (rd_byte == CH_SEMI && j_reg > d0_reg && 32'(v_reg) >= 32'(PRINT_LO)
                        && 32'(v_reg) < 32'(PRINT_HI)) begin
                    dec_go  = 1'b1;
                    dec_len = j_reg + CW'(1);
                    dec_ch  = v_reg[7:0];
                end else begin
                    fail = 1'b1;
                end
            end else begin
                num_step = 1'b1;
            end
        end
        if (und) begin
            if (la_cnt_reg >= CW'(LOOKAHEAD_DEPTH)) begin
                fail = 1'b1;
            end else begin
                dec_wait = 1'b1;
            end
        end
        if (fail) begin
            dec_go  = 1'b1;
            dec_len = CW'(1);
            dec_ch  = CH_AMP;
        end
    end

    // UTF-8 tail holding
    always_comb begin
        e_cont = (emit_c_reg[7:6] == 2'b10);
        if ((emit_c_reg & 8'hf8) == 8'hf0) begin
            e_want = 3'd4;
        end else if ((emit_c_reg & 8'hf0) == 8'he0) begin
            e_want = 3'd3;
        end else if ((emit_c_reg & 8'he0) == 8'hc0) begin
            e_want = 3'd2;
        end else begin
            e_want = 3'd1;
        end
        held_nz     = (held_cnt_reg != 2'd0);
        e_flush     = e_cont ? (held_nz && (3'(held_cnt_reg) + 3'd1 >= want_reg
                                            || held_cnt_reg == 2'd3))
                             : 1'b1;
        e_flushing  = e_flush && (fi_reg < held_cnt_reg);
        e_final_put = e_cont ? (!held_nz || e_flush) : (e_want == 3'd1);
        e_put       = e_flushing || e_final_put;
        e_adv       = !e_put || ost.put_ok;
    end

    assign t_ws = (take_c_reg == CH_SPACE) || (take_c_reg == CH_TAB)
               || (take_c_reg == CH_CR) || (take_c_reg == CH_LF);
    assign cap_hit1 = ({1'b0, cnt_reg} + 14'd1) >= {1'b0, cap_reg};
    assign cap_hit2 = ({1'b0, cnt_reg} + 14'd2) >= {1'b0, cap_reg};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (reached_reg) begin
                        state_next = ST_POST;
                    end else if (la_cnt_reg != '0) begin
                        state_next = ST_DEC;
                    end else begin
                        state_next = ST_TAKE;
                    end
                end
            end
            ST_POST: begin
                if (ended_reg) begin
                    state_next = ST_FINAL;
                end else if (last_reg) begin
                    state_next = (la_cnt_reg != '0) ? ST_DEC : ST_FINAL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DEC, ST_NUM: begin
                if (dec_go) begin
                    state_next = ST_EMIT;
                end else if (dec_wait) begin
                    state_next = ST_POST;
                end else if (num_start) begin
                    state_next = ST_NUM;
                end
            end
            ST_EMIT: begin
                if (e_adv && !e_flushing) begin
                    state_next = emit_ret_reg;
                end
            end
            ST_REPLAY: begin
                if (rp_src_reg < rp_end_reg) begin
                    state_next = (la_cnt_reg != '0) ? ST_REPLAY : ST_TAKE;
                end else begin
                    state_next = (la_cnt_reg != '0) ? ST_DEC : ST_POST;
                end
            end
            ST_TAKE: begin
                if (reached_reg || cap_hit1 || t_ws || (sp_reg && cap_hit2)) begin
                    state_next = take_ret_reg;
                end else if (sp_reg) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_TAKE2;
                end
            end
            ST_TAKE2: begin
                state_next = (take_c_reg == CH_AMP) ? take_ret_reg : ST_EMIT;
            end
            ST_FINAL: begin
                if (ost.fin_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        la_cnt_next   = la_cnt_reg;
        cnt_next      = cnt_reg;
        sp_next       = sp_reg;
        held_cnt_next = held_cnt_reg;
        want_next     = want_reg;
        reached_next  = reached_reg;
        last_next     = last_reg;
        ended_next    = ended_reg;
        step_put_next = step_put_reg;
        take_c_next   = take_c_reg;
        take_ret_next = take_ret_reg;
        emit_c_next   = emit_c_reg;
        emit_ret_next = emit_ret_reg;
        fi_next       = fi_reg;
        j_next        = j_reg;
        d0_next       = d0_reg;
        hex_next      = hex_reg;
        v_next        = v_reg;
        rp_src_next   = rp_src_reg;
        rp_end_next   = rp_end_reg;
        lb_we         = 1'b0;
        lb_wa         = la_cnt_reg[IW-1:0];
        lb_wd         = rd_byte;
        held_we       = 1'b0;
        held_wa       = held_cnt_reg;
        held_wd       = emit_c_reg;
        oreq          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    take_c_next   = s_tdata;
                    last_next     = s_tlast;
                    ended_next    = 1'b0;
                    step_put_next = 1'b0;
                    take_ret_next = ST_POST;
                    if (!reached_reg && la_cnt_reg != '0
                            && la_cnt_reg < CW'(LOOKAHEAD_DEPTH)) begin
                        lb_we       = 1'b1;
                        lb_wd       = s_tdata;
                        la_cnt_next = la_cnt_reg + CW'(1);
                    end
                end
            end
            ST_POST: begin
                if (!ended_reg && last_reg) begin
                    ended_next = 1'b1;
                end
            end
            ST_DEC, ST_NUM: begin
                if (dec_go) begin
                    emit_c_next   = dec_ch;
                    emit_ret_next = ST_REPLAY;
                    rp_src_next   = dec_len;
                    rp_end_next   = la_cnt_reg;
                    la_cnt_next   = '0;
                end else if (num_start) begin
                    hex_next = (lb_reg[2] == CH_LX) || (lb_reg[2] == CH_UX);
                    j_next   = hex_next ? CW'(3) : CW'(2);
                    d0_next  = j_next;
                    v_next   = '0;
                end else if (num_step) begin
                    v_next = du_acc;
                    j_next = j_reg + CW'(1);
                end
            end
            ST_EMIT: begin
                if (e_adv) begin
                    if (e_put) begin
                        step_put_next = 1'b1;
                    end
                    if (e_flushing) begin
                        oreq.put  = 1'b1;
                        oreq.data = held_reg[fi_reg];
                        fi_next   = fi_reg + 2'd1;
                    end else begin
                        oreq.put  = e_final_put;
                        oreq.data = emit_c_reg;
                        cnt_next  = cnt_reg + CAP_W'(1);
                        fi_next   = 2'd0;
                        if (e_cont) begin
                            if (held_nz && !e_flush) begin
                                held_we       = 1'b1;
                                held_cnt_next = held_cnt_reg + 2'd1;
                            end else if (held_nz) begin
                                held_cnt_next = 2'd0;
                                want_next     = 3'd0;
                            end
                        end else if (e_want != 3'd1) begin
                            held_we       = 1'b1;
                            held_wa       = 2'd0;
                            held_cnt_next = 2'd1;
                            want_next     = e_want;
                        end else begin
                            held_cnt_next = 2'd0;
                            want_next     = 3'd0;
                        end
                    end
                end
            end
            ST_REPLAY: begin
                if (rp_src_reg < rp_end_reg) begin
                    rp_src_next = rp_src_reg + CW'(1);
                    if (la_cnt_reg != '0) begin
                        lb_we       = 1'b1;
                        la_cnt_next = la_cnt_reg + CW'(1);
                    end else begin
                        take_c_next   = rd_byte;
                        take_ret_next = ST_REPLAY;
                    end
                end
            end
            ST_TAKE: begin
                if (!reached_reg) begin
                    if (cap_hit1) begin
                        reached_next = 1'b1;
                    end else if (t_ws) begin
                        sp_next = (cnt_reg != '0);
                    end else if (sp_reg) begin
                        if (cap_hit2) begin
                            reached_next = 1'b1;
                        end else begin
                            emit_c_next   = CH_SPACE;
                            emit_ret_next = ST_TAKE2;
                            sp_next       = 1'b0;
                        end
                    end
                end
            end
            ST_TAKE2: begin
                if (take_c_reg == CH_AMP) begin
                    lb_we       = 1'b1;
                    lb_wa       = '0;
                    lb_wd       = CH_AMP;
                    la_cnt_next = CW'(1);
                end else begin
                    emit_c_next   = take_c_reg;
                    emit_ret_next = take_ret_reg;
                end
            end
            ST_FINAL: begin
                oreq.fin  = 1'b1;
                oreq.bare = !step_put_reg;
                if (ost.fin_done) begin
                    la_cnt_next   = '0;
                    cnt_next      = '0;
                    sp_next       = 1'b0;
                    held_cnt_next = 2'd0;
                    want_next     = 3'd0;
                    reached_next  = 1'b0;
                    ended_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            la_cnt_reg   <= '0;
            cnt_reg      <= '0;
            sp_reg       <= 1'b0;
            held_cnt_reg <= 2'd0;
            want_reg     <= 3'd0;
            reached_reg  <= 1'b0;
            last_reg     <= 1'b0;
            ended_reg    <= 1'b0;
            step_put_reg <= 1'b0;
            fi_reg       <= 2'd0;
        end else begin
            state_reg    <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            la_cnt_reg   <= la_cnt_next;
            cnt_reg      <= cnt_next;
            sp_reg       <= sp_next;
            held_cnt_reg <= held_cnt_next;
            want_reg     <= want_next;
            reached_reg  <= reached_next;
            last_reg     <= last_next;
            ended_reg    <= ended_next;
            step_put_reg <= step_put_next;
            fi_reg       <= fi_next;
        end
    end

    always_ff @(posedge aclk) begin
        take_c_reg   <= take_c_next;
        take_ret_reg <= take_ret_next;
        emit_c_reg   <= emit_c_next;
        emit_ret_reg <= emit_ret_next;
        j_reg        <= j_next;
        d0_reg       <= d0_next;
        hex_reg      <= hex_next;
        v_reg        <= v_next;
        rp_src_reg   <= rp_src_next;
        rp_end_reg   <= rp_end_next;
        if (lb_we) begin
            lb_reg[lb_wa] <= lb_wd;
        end
        if (held_we) begin
            held_reg[held_wa] <= held_wd;
        end
    end

    `HTC_ALWAYS(a_la_bound, la_cnt_reg <= CW'(LOOKAHEAD_DEPTH), "lookahead count overrun")
    `HTC_ALWAYS(a_idle_room, state_reg != ST_IDLE || la_cnt_reg < CW'(LOOKAHEAD_DEPTH), "idle full")
    `HTC_ALWAYS(a_held_want, held_cnt_reg == 2'd0 || want_reg > 3'(held_cnt_reg), "held tail done")
    `HTC_NEXT(a_fin_last, state_reg == ST_FINAL && ost.fin_done, m_tvalid && m_tlast, "no span end")

endmodule
`default_nettype wire
